@@ design/kpnms_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and register codes of the 3x3 keypoint suppression block
package kpnms_pkg;

	localparam int SCORE_BITS    = 16;
	localparam int POS_X_BITS    = 10;
	localparam int POS_Y_BITS    = 12;
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 12;
	localparam int CFG_B_BITS    = 4;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_LVL_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH  = CFG_W_BITS'(640);
	localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT = CFG_H_BITS'(480);
	localparam logic [CFG_B_BITS-1:0] RST_BORDER_WIDTH = CFG_B_BITS'(2);

	localparam logic KIND_KEYPOINT = 1'b0;
	localparam logic KIND_END      = 1'b1;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_BORDER_WIDTH    = 2'd2,
		REG_SCORE_THRESHOLD = 2'd3
	} reg_idx_t;

	typedef logic signed [SCORE_BITS-1:0] score_t;

	typedef struct packed {
		score_t score;
		logic   frame_start;
	} pixel_t;

	typedef struct packed {
		logic                  kind;
		logic [POS_X_BITS-1:0] pos_x;
		logic [POS_Y_BITS-1:0] pos_y;
		score_t                peak_score;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [CFG_W_BITS-1:0] image_width;
		logic [CFG_H_BITS-1:0] image_height;
		logic [CFG_B_BITS-1:0] border_width;
		score_t                score_threshold;
	} cfg_t;

	// one queue entry: what a pixel caused, carried out later by the back end
	typedef struct packed {
		logic                  has_key;
		logic                  has_eof;
		logic [POS_X_BITS-1:0] pos_x;
		logic [POS_Y_BITS-1:0] pos_y;
		score_t                score;
	} ent_t;

endpackage

@@ design/kpnms_cfg.sv @@
`timescale 1ns / 1ps
// apb register file holding geometry and threshold
module kpnms_cfg import kpnms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_IMAGE_WIDTH;
			cfg_q.image_height    <= RST_IMAGE_HEIGHT;
			cfg_q.border_width    <= RST_BORDER_WIDTH;
			cfg_q.score_threshold <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= pwdata[CFG_W_BITS-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= pwdata[CFG_H_BITS-1:0];
				end
				REG_BORDER_WIDTH: begin
					cfg_q.border_width <= pwdata[CFG_B_BITS-1:0];
				end
				REG_SCORE_THRESHOLD: begin
					cfg_q.score_threshold <= signed'(pwdata[SCORE_BITS-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:     prdata = APB_DATA_BITS'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:    prdata = APB_DATA_BITS'(cfg_q.image_height);
			REG_BORDER_WIDTH:    prdata = APB_DATA_BITS'(cfg_q.border_width);
			REG_SCORE_THRESHOLD: begin
				prdata = {{(APB_DATA_BITS-SCORE_BITS){1'b0}}, cfg_q.score_threshold};
			end
			default:             prdata = '0;
		endcase
	end

endmodule

@@ design/kpnms_front.sv @@
`timescale 1ns / 1ps
// front end: position tracking, line memory, 3x3 window and peak test
module kpnms_front import kpnms_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  pixel_t                    pixel,
	output logic                      full,
	input  cfg_t                      cfg,
	input  logic [QUEUE_LVL_BITS-1:0] q_level,
	output logic                      ent_push,
	output ent_t                      ent
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int CW  = (CFG_W_BITS > WB) ? CFG_W_BITS : WB;
	localparam int SW  = CW + 2;
	localparam int YB  = CFG_H_BITS;
	localparam int YSW = CFG_H_BITS + 2;
	localparam int LW  = QUEUE_LVL_BITS + 1;
	localparam int MW  = 2 * SCORE_BITS;

	// clamped geometry
	logic [CW-1:0]         w_raw, w_eff;
	logic [YB-1:0]         h_eff;
	logic [CFG_B_BITS-1:0] b_eff;

	// position of the arriving pixel
	logic [XW-1:0]  col_q, x_cur;
	logic [YB-1:0]  row_q, y_cur;
	logic signed [SW-1:0]  xs, ws, bxs, wmb;
	logic signed [YSW-1:0] ys, hs, bys, hmb;
	logic inband, kpos, at_last, accept;
	logic [CW-1:0]  x_inc;
	logic [YB:0]    y_inc;
	logic           x_wrap, y_wrap;
	score_t         v_cur;

	// line memory: {two rows up, one row up} per column
	logic [MW-1:0]  mem [MAX_WIDTH];
	logic           clr_q;
	logic [XW-1:0]  clr_addr_q;

	// stage 1
	logic           valid_s1, kpos_s1, last_s1, byp_s1, hit;
	logic [XW-1:0]  x_s1;
	logic [YB-1:0]  y_s1;
	score_t         v_s1;
	logic [MW-1:0]  rd_s1, bypd_s1, line_s1, wdata_s1;

	// stage 2
	logic           valid_s2, kpos_s2, last_s2, dom, key;
	logic [XW-1:0]  x_s2, x_m1;
	logic [YB-1:0]  y_s2;
	score_t         win_q [3][3];
	score_t         c;

	always_comb begin
		w_raw = CW'(cfg.image_width);
		if (w_raw < CW'(3)) begin
			w_eff = CW'(3);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		h_eff = (cfg.image_height < YB'(3)) ? YB'(3) : cfg.image_height;
		b_eff = (cfg.border_width == '0) ? CFG_B_BITS'(1) : cfg.border_width;
	end

	assign x_cur = pixel.frame_start ? '0 : col_q;
	assign y_cur = pixel.frame_start ? '0 : row_q;

	assign xs  = signed'(SW'(x_cur));
	assign ws  = signed'(SW'(w_eff));
	assign bxs = signed'(SW'(b_eff));
	assign wmb = ws - bxs;
	assign ys  = signed'(YSW'(y_cur));
	assign hs  = signed'(YSW'(h_eff));
	assign bys = signed'(YSW'(b_eff));
	assign hmb = hs - bys;

	assign inband  = (xs >= bxs) && (xs < wmb) && (ys >= bys) && (ys < hmb);
	// centre one column left and one row up lies inside the band
	assign kpos    = (xs > bxs) && (xs <= wmb) && (ys > bys) && (ys <= hmb);
	assign at_last = (CW'(x_cur) == w_eff - CW'(1)) && (y_cur == h_eff - YB'(1));
	assign v_cur   = inband ? pixel.score : '0;

	assign x_inc  = CW'(x_cur) + CW'(1);
	assign x_wrap = x_inc >= w_eff;
	assign y_inc  = {1'b0, y_cur} + (YB+1)'(1);
	assign y_wrap = y_inc >= {1'b0, h_eff};

	assign full   = clr_q ||
		((LW'(q_level) + LW'(valid_s1) + LW'(valid_s2)) >= LW'(QUEUE_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (x_wrap) begin
				col_q <= '0;
				row_q <= y_wrap ? '0 : y_inc[YB-1:0];
			end else begin
				col_q <= x_inc[XW-1:0];
				row_q <= y_cur;
			end
		end
	end

	// clearing sweep of the line memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == XW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + XW'(1);
			end
		end
	end

	// write of the previous pixel races the read of the next one at the same column
	assign hit      = valid_s1 && (x_cur == x_s1);
	assign line_s1  = byp_s1 ? bypd_s1 : rd_s1;
	assign wdata_s1 = {line_s1[SCORE_BITS-1:0], v_s1};

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (valid_s1) begin
			mem[x_s1] <= wdata_s1;
		end
		rd_s1   <= mem[x_cur];
		byp_s1  <= hit;
		bypd_s1 <= wdata_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_cur;
			y_s1    <= y_cur;
			v_s1    <= v_cur;
			kpos_s1 <= kpos;
			last_s1 <= at_last;
		end
		if (valid_s1) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			kpos_s2 <= kpos_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= signed'(line_s1[MW-1:SCORE_BITS]);
			win_q[1][2] <= signed'(line_s1[SCORE_BITS-1:0]);
			win_q[2][2] <= v_s1;
		end
	end

	assign c = win_q[1][1];

	always_comb begin
		dom = 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (win_q[r][k] > c) begin
					dom = 1'b0;
				end
			end
		end
	end

	assign key  = kpos_s2 && (c > cfg.score_threshold) && dom;
	assign x_m1 = x_s2 - XW'(1);

	assign ent_push    = valid_s2 && (key || last_s2);
	assign ent.has_key = key;
	assign ent.has_eof = last_s2;
	assign ent.pos_x   = POS_X_BITS'(x_m1);
	assign ent.pos_y   = y_s2 - YB'(1);
	assign ent.score   = c;

endmodule

@@ design/kpnms_queue.sv @@
`timescale 1ns / 1ps
// short show-ahead queue between the front and back ends
module kpnms_queue import kpnms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr,
	input  ent_t                      wdata,
	input  logic                      rd,
	output ent_t                      rdata,
	output logic                      q_empty,
	output logic [QUEUE_LVL_BITS-1:0] level
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	ent_t                      ent_q [QUEUE_DEPTH];
	logic [AW-1:0]             wptr_q, rptr_q;
	logic [QUEUE_LVL_BITS-1:0] cnt_q;
	logic                      do_rd;

	assign q_empty = (cnt_q == '0);
	assign level   = cnt_q;
	assign rdata   = ent_q[rptr_q];
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			cnt_q <= cnt_q + QUEUE_LVL_BITS'(wr) - QUEUE_LVL_BITS'(do_rd);
		end
	end

endmodule

@@ design/kpnms_back.sv @@
`timescale 1ns / 1ps
// back end: splits queue entries into keypoint and end items, output register
module kpnms_back import kpnms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ent_t    head,
	input  logic    head_valid,
	output logic    q_rd,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic    out_valid_q, phase_q;
	result_t out_q, item;
	logic    out_free, load, emit_key;

	assign out_free = !out_valid_q || pop;
	assign load     = out_free && head_valid;
	assign emit_key = head.has_key && !phase_q;
	assign q_rd     = load && !(emit_key && head.has_eof);

	always_comb begin
		if (emit_key) begin
			item.kind       = KIND_KEYPOINT;
			item.pos_x      = head.pos_x;
			item.pos_y      = head.pos_y;
			item.peak_score = head.score;
			item.last       = !head.has_eof;
		end else begin
			item.kind       = KIND_END;
			item.pos_x      = '0;
			item.pos_y      = '0;
			item.peak_score = '0;
			item.last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			phase_q     <= emit_key && head.has_eof;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ design/keypoint_nms_3x3.sv @@
`timescale 1ns / 1ps
// top level of the 3x3 keypoint non-maximum suppression block
//
// Score-map samples (signed Q4.12) enter in raster order through a push/full queue port,
// one item per clock while full is low; keypoints and end-of-frame markers leave through
// an empty/pop queue port. Samples inside the border band are forced to zero; an interior
// pixel is a keypoint when its score is strictly above score_threshold and no sample of
// its 3x3 neighborhood is larger. A keypoint at (x, y) is found when pixel (x+1, y+1)
// arrives and then passes both front stages, the queue and the output register; after
// the last pixel of a frame an end item follows (behind the keypoint if that pixel also
// completed one), with last set on the final item of each pixel. The front end sustains
// one pixel per clock while full is low: each column has one line-memory word holding
// the two rows above, read and rewritten once per pixel with a bypass for back-to-back
// hits on the same column. A four-entry queue separates it from the back end, which
// issues one result item per clock while pop keeps up; apart from the clearing sweep,
// full rises only when that queue plus the two front stages could overflow, i.e. when
// the result side stalls or a pixel yields two items in a row. After reset the line
// memory is swept to zero, one column per clock, with full high until the sweep ends.
// Registers sit on an APB port at byte addresses 0x0 width, 0x4 height, 0x8 border,
// 0xC threshold; write them only while no pixels are in flight.
module keypoint_nms_3x3 import kpnms_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// pixel side
	input  logic                     push,
	output logic                     full,
	input  pixel_t                   pixel,
	// result side
	output logic                     empty,
	input  logic                     pop,
	output result_t                  result,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t                      cfg;
	logic                      ent_push, q_rd, q_empty;
	ent_t                      ent, head;
	logic [QUEUE_LVL_BITS-1:0] q_level;

	// register file
	kpnms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pixel pipeline: counters, line memory, window, peak test
	kpnms_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pixel    (pixel),
		.full     (full),
		.cfg      (cfg),
		.q_level  (q_level),
		.ent_push (ent_push),
		.ent      (ent)
	);

	// decoupling queue, one entry per pixel that caused any result
	kpnms_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ent_push),
		.wdata   (ent),
		.rd      (q_rd),
		.rdata   (head),
		.q_empty (q_empty),
		.level   (q_level)
	);

	// result formatting and output register
	kpnms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

@@ tb/keypoint_nms_3x3_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the 3x3 keypoint suppression block: predicted results vs. dut
module keypoint_nms_3x3_tb;
	import kpnms_pkg::*;

	// keeps a bit-level copy of the block's state and the list of results still owed
	class nms_scoreboard;
		logic [CFG_W_BITS-1:0] cfg_w;
		logic [CFG_H_BITS-1:0] cfg_h;
		logic [CFG_B_BITS-1:0] cfg_b;
		score_t                cfg_thr;
		score_t                line_mem[2][DEF_MAX_WIDTH];
		score_t                win[3][3];
		int                    col;
		int                    row;
		result_t               results_due[$];
		int                    errors;

		function new();
			cfg_w   = RST_IMAGE_WIDTH;
			cfg_h   = RST_IMAGE_HEIGHT;
			cfg_b   = RST_BORDER_WIDTH;
			cfg_thr = '0;
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
			foreach (win[i, j]) win[i][j] = '0;
			col    = 0;
			row    = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH:     cfg_w = value[CFG_W_BITS-1:0];
				REG_IMAGE_HEIGHT:    cfg_h = value[CFG_H_BITS-1:0];
				REG_BORDER_WIDTH:    cfg_b = value[CFG_B_BITS-1:0];
				REG_SCORE_THRESHOLD: cfg_thr = value[SCORE_BITS-1:0];
				default: ;
			endcase
		endfunction

		// geometry as the block uses it, after clamping
		function int eff_width();
			int w;
			w = cfg_w;
			if (w < 3) w = 3;
			if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
			return w;
		endfunction

		function int eff_height();
			int h;
			h = cfg_h;
			if (h < 3) h = 3;
			return h;
		endfunction

		function int eff_border();
			int b;
			b = cfg_b;
			if (b < 1) b = 1;
			return b;
		endfunction

		function void note_pixel(pixel_t p);
			int      w, h, b, thr, x, y, v, c;
			bit      key, at_end;
			result_t kp, eof;
			w   = eff_width();
			h   = eff_height();
			b   = eff_border();
			thr = cfg_thr;
			if (p.frame_start) begin
				col = 0;
				row = 0;
			end
			x = col;
			y = row;
			v = p.score;
			if (x < b || x >= w - b || y < b || y >= h - b)
				v = 0;
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2]      = line_mem[1][x];
			win[1][2]      = line_mem[0][x];
			win[2][2]      = score_t'(v);
			line_mem[1][x] = line_mem[0][x];
			line_mem[0][x] = score_t'(v);
			c   = win[1][1];
			key = (x - 1 >= b) && (x - 1 < w - b) && (y - 1 >= b) && (y - 1 < h - b) && (c > thr);
			if (key)
				foreach (win[i, j])
					if (int'(win[i][j]) > c) key = 1'b0;
			at_end = (x == w - 1) && (y == h - 1);
			if (key) begin
				kp.kind       = KIND_KEYPOINT;
				kp.pos_x      = POS_X_BITS'(x - 1);
				kp.pos_y      = POS_Y_BITS'(y - 1);
				kp.peak_score = score_t'(c);
				kp.last       = !at_end;
				results_due   = {results_due, kp};
			end
			if (at_end) begin
				eof         = '0;
				eof.kind    = KIND_END;
				eof.last    = 1'b1;
				results_due = {results_due, eof};
			end
			if (x + 1 >= w) begin
				col = 0;
				row = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				col = x + 1;
			end
		endfunction

		function void report(string what, result_t want, result_t got);
			if (errors < 10)
				$display("%s: want kind=%0d x=%0d y=%0d score=%0d last=%0d,",
					what, want.kind, want.pos_x, want.pos_y, want.peak_score, want.last,
					" got kind=%0d x=%0d y=%0d score=%0d last=%0d",
					got.kind, got.pos_x, got.pos_y, got.peak_score, got.last);
			errors++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (results_due.size() == 0) begin
				report("unexpected result", '0, got);
				return;
			end
			want = results_due.pop_front();
			bad  = (got.kind !== want.kind) || (got.pos_x !== want.pos_x) ||
				(got.pos_y !== want.pos_y) || (got.peak_score !== want.peak_score) ||
				(got.last !== want.last);
			if (bad) report("result mismatch", want, got);
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	pixel_t                   pixel;
	logic                     empty;
	logic                     pop;
	result_t                  result;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	nms_scoreboard sb;
	int            burst_left;   // items left in the current sender burst
	int            items_sent;
	bit            hold_req;     // asks the receiver for one long hold-off

	keypoint_nms_3x3 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// generous limit, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// sample both handshakes at the rising edge, before the dut's flops move
	always @(posedge clk) begin
		if (arst_n && push && !full) sb.note_pixel(pixel);
		if (arst_n && pop && !empty) sb.check_result(result);
	end

	// receiver: keeps each random stall pattern for a random stretch, plus one long hold-off
	initial begin
		int mode;
		int left;
		pop  = 1'b0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long stall so the result queue backs up and full rises
				pop = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 96);
			end
			left--;
			case (mode)
				0: pop = 1'b1;
				1: pop = $urandom_range(0, 1);
				2: pop = ($urandom_range(0, 3) == 0);
				default: pop = (left % 3 != 0);
			endcase
		end
	end

	// one register write: setup cycle, then access cycle until pready
	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = APB_ADDR_BITS'(int'(idx) * 4);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// offer one item; bursts of random length with random gaps in between
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
		end
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push  = 1'b1;
		pixel = p;
		do @(posedge clk); while (full);
		burst_left--;
		items_sent++;
	endtask

	// stop offering, let every owed result come out, then give the pipeline time to empty
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		while (full) @(negedge clk);
	endtask

	task automatic setup(input int w, input int h, input int b, input logic [SCORE_BITS-1:0] thr);
		settle();
		apb_write(REG_IMAGE_WIDTH, APB_DATA_BITS'(w));
		apb_write(REG_IMAGE_HEIGHT, APB_DATA_BITS'(h));
		apb_write(REG_BORDER_WIDTH, APB_DATA_BITS'(b));
		apb_write(REG_SCORE_THRESHOLD, APB_DATA_BITS'(thr));
	endtask

	// score content: full range, tiny values full of ties, sparse peaks, extremes only
	function automatic score_t pick_score(input int mode);
		int r;
		case (mode)
			0: return score_t'($urandom);
			1: return score_t'($urandom_range(0, 3) - 1);
			2: return ($urandom_range(0, 15) == 0) ? score_t'($urandom_range(16384, 32767))
				: score_t'($urandom_range(0, 255));
			default: begin
				r = $urandom_range(0, 2);
				return (r == 0) ? 16'sh7fff : (r == 1) ? 16'sh8000 : '0;
			end
		endcase
	endfunction

	// stray_at places an extra frame start mid-frame (out of range means none)
	task automatic send_frame(input int npix, input bit with_start, input int stray_at,
		input int mode);
		pixel_t p;
		for (int i = 0; i < npix; i++) begin
			p.frame_start = (i == 0 && with_start) || (i == stray_at);
			p.score       = pick_score(mode);
			send_pixel(p);
		end
	endtask

	// 3x3 frame: the ring lies in the border band and is zeroed, so only the center counts
	task automatic send_tiny_frame(input score_t center);
		pixel_t p;
		for (int i = 0; i < 9; i++) begin
			p.frame_start = (i == 0);
			p.score       = (i == 4) ? center : (i % 2 ? 16'sh7fff : 16'sh8000);
			send_pixel(p);
		end
	endtask

	initial begin
		int  rand_target;
		int  w_reg, h_reg, b_reg, r;
		int  full_len, npix, stray_at;
		bit  hold_done;
		logic [SCORE_BITS-1:0] thr;
		sb         = new();
		arst_n     = 1'b0;
		push       = 1'b0;
		pixel      = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		burst_left = 0;
		items_sent = 0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: smallest frame, lowest threshold, a zero center ties with the zeroed ring
		setup(3, 3, 1, 16'h8000);
		send_tiny_frame('0);
		// largest score as the only keypoint, found on the last pixel with the end item
		send_tiny_frame(16'sh7fff);
		// zero border acts as one; highest threshold leaves only the end item
		setup(3, 3, 0, 16'h7fff);
		send_tiny_frame(16'sh7fff);

		// widest line: exercises every column of the line memory and the wrap to the next row
		setup(DEF_MAX_WIDTH, 3, 1, 16'h0000);
		send_frame(DEF_MAX_WIDTH + 8, 1'b1, -1, 2);
		// tallest setting, cut short by the next frame start
		setup(3, 4095, 1, 16'hffff);
		send_frame(60, 1'b1, -1, 1);
		// clamped geometry with a band wider than the image: end items only
		setup(0, 0, 15, 16'h8000);
		send_frame(9, 1'b1, -1, 0);
		send_frame(9, 1'b1, -1, 3);

		// random phases: mostly small well-formed frames, some cut, restarted or unmarked
		rand_target = items_sent + 620;
		while (items_sent < rand_target) begin
			// once, well into the run: receiver stalls while the sender keeps pushing
			// tiny frames, two results each, so the queue backs up and full rises
			if (!hold_done && items_sent > rand_target - 450) begin
				setup(3, 3, 1, 16'h8000);
				hold_req  = 1'b1;
				hold_done = 1'b1;
				repeat (20) send_tiny_frame(16'sh0100);
			end
			r     = $urandom_range(0, 99);
			w_reg = (r < 70) ? $urandom_range(3, 12) : (r < 80) ? $urandom_range(0, 2)
				: (r < 92) ? $urandom_range(13, 40) : $urandom_range(0, 2047);
			r     = $urandom_range(0, 99);
			h_reg = (r < 75) ? $urandom_range(3, 10) : (r < 85) ? $urandom_range(0, 2)
				: (r < 95) ? $urandom_range(11, 30) : $urandom_range(0, 4095);
			r     = $urandom_range(0, 99);
			b_reg = (r < 60) ? $urandom_range(1, 2) : (r < 70) ? 0 : $urandom_range(3, 15);
			r     = $urandom_range(0, 99);
			thr   = (r < 50) ? SCORE_BITS'($urandom_range(0, 4) - 2)
				: (r < 75) ? SCORE_BITS'($urandom) : SCORE_BITS'($urandom_range(0, 300));
			setup(w_reg, h_reg, b_reg, thr);
			repeat ($urandom_range(1, 4)) begin
				full_len = sb.eff_width() * sb.eff_height();
				npix     = full_len;
				if (full_len > 300)
					npix = $urandom_range(40, 300);
				else if ($urandom_range(0, 9) == 0)
					npix = $urandom_range(1, full_len);
				stray_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, npix) : -1;
				send_frame(npix, $urandom_range(0, 9) != 0, stray_at, $urandom_range(0, 3));
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
